### rtl/core/lhp_pkg.sv
`default_nettype none

package lhp_pkg;

   // register indexes on the csr port
   localparam logic CSR_FULL_SCALE  = 1'b0;
   localparam logic CSR_ACTIVE_BINS = 1'b1;

   localparam int unsigned SCALE_W    = 32;
   localparam int unsigned NBINS_W    = 11;
   localparam int unsigned SAMPLE_W   = 32;
   localparam int unsigned TOTAL_W    = 48;
   localparam int unsigned Q4_W       = 36;
   localparam int unsigned JIT_W      = 16;
   localparam int unsigned ODD_W      = 12;   // 2*i+1 for i < 2048

   localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd1000000;
   localparam logic [NBINS_W-1:0] NBINS_RESET = 11'd1024;

   // shared divider
   localparam int unsigned DIV_NUM_W  = 47;
   localparam int unsigned DIV_DEN_W  = 32;
   localparam int unsigned DIV_STEP_W = 6;
   localparam logic [DIV_STEP_W-1:0] STEPS_INDEX = 6'd11;
   localparam logic [DIV_STEP_W-1:0] STEPS_FULL  = 6'd47;

   // rank thresholds, percent
   localparam int unsigned PCT_50  = 50;
   localparam int unsigned PCT_95  = 95;
   localparam int unsigned PCT_99  = 99;
   localparam int unsigned PCT_ALL = 100;

   typedef enum logic [1:0] {
      SEL_P50,
      SEL_P95,
      SEL_P99,
      SEL_JIT
   } lhp_sel_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_IDX,
      ST_IDX_WAIT,
      ST_READ,
      ST_WRITE,
      ST_SUM,
      ST_SUM_DRAIN,
      ST_TARGET,
      ST_WALK,
      ST_WALK_DRAIN,
      ST_CMUL,
      ST_CDIV,
      ST_CWAIT,
      ST_OUT
   } lhp_state_type;

   typedef struct packed {
      logic clr_wr;
      logic cnt_rst;
      logic cnt_inc;
      logic take;
      logic mul;
      logic idx_start;
      logic idx_from_div;
      logic rd_idx;
      logic wr_idx;
      logic walk_rd;
      logic walk;
      logic acc_clear;
      logic tgt_load;
      logic sel_rst;
      logic cmul;
      logic cdiv_start;
      logic cstore;
      logic out_load;
      logic out_zero;
   } lhp_cmd_type;

   typedef struct packed {
      logic over;
      logic clr_last;
      logic walk_last;
      logic div_done;
      logic pipe_busy;
      logic total_zero;
      logic sel_last;
      logic out_free;
   } lhp_status_type;

endpackage

`default_nettype wire

### rtl/core/latency_histogram_percentiles.sv
`default_nettype none

// channel  | direction | handshake            | payload
// req      | in        | req_valid/req_stall  | req_mode, req_sample
// rsp      | out       | rsp_valid/rsp_stall  | median, p95, p99, peak (Q.4), jitter (Q8.8)
// csr      | in        | csr_write_enable     | csr_index, csr_write_data
//
// After reset a clearing pass zeroes the bin memory, with req_stall high.
// Add-sample transaction: the 11-step index divide (skipped when sample >= full scale),
//   then the bin read-modify-write through the memory read and write ports.
// Report transaction: two walks over the bins through the memory read port, then four
//   47-step divides on the shared divider; an empty histogram returns all zeros instead.
// One transaction in flight; a pending result waits in the output register while
//   the next transaction is accepted, and only a report stalls on a full register.

module latency_histogram_percentiles #(
   parameter int unsigned MAX_BINS    = 1024,
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_mode,
   input  wire logic signed [31:0]              req_sample,
   // result channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [lhp_pkg::Q4_W-1:0]             rsp_median_q4,
   output logic [lhp_pkg::Q4_W-1:0]             rsp_p95_q4,
   output logic [lhp_pkg::Q4_W-1:0]             rsp_p99_q4,
   output logic [lhp_pkg::Q4_W-1:0]             rsp_peak_q4,
   output logic [lhp_pkg::JIT_W-1:0]            rsp_jitter_q8_8,
   // configuration
   input  wire logic                            csr_write_enable,
   input  wire logic                            csr_index,
   input  wire logic [31:0]                     csr_write_data
);

   lhp_pkg::lhp_cmd_type    cmd;
   lhp_pkg::lhp_status_type status;

   // sequencer: clear pass, sample update, two-pass percentile walk
   lhp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // bin memory, accumulators, shared divider, result register
   lhp_dp #(
      .MAX_BINS    (MAX_BINS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_sample       (req_sample),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_median_q4    (rsp_median_q4),
      .rsp_p95_q4       (rsp_p95_q4),
      .rsp_p99_q4       (rsp_p99_q4),
      .rsp_peak_q4      (rsp_peak_q4),
      .rsp_jitter_q8_8  (rsp_jitter_q8_8)
   );

endmodule

`default_nettype wire

### rtl/core/lhp_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
// caller guarantees (numer >> steps) < denom
module lhp_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [lhp_pkg::DIV_NUM_W-1:0]      numer,
   input  wire logic [lhp_pkg::DIV_DEN_W-1:0]      denom,
   input  wire logic [lhp_pkg::DIV_STEP_W-1:0]     steps,
   output logic                                     done,
   output logic [lhp_pkg::DIV_NUM_W-1:0]           quot
);

   logic [lhp_pkg::DIV_DEN_W-1:0]  rem_ff;
   logic [lhp_pkg::DIV_DEN_W-1:0]  den_ff;
   logic [lhp_pkg::DIV_NUM_W-1:0]  sh_ff;
   logic [lhp_pkg::DIV_NUM_W-1:0]  quot_ff;
   logic [lhp_pkg::DIV_STEP_W-1:0] cnt_ff;
   logic                           busy_ff;
   logic                           done_ff;

   logic [lhp_pkg::DIV_DEN_W:0]    trial;
   logic                           take_bit;
   logic [lhp_pkg::DIV_DEN_W:0]    diff;

   assign trial    = {rem_ff, sh_ff[lhp_pkg::DIV_NUM_W-1]};
   assign take_bit = (trial >= {1'b0, den_ff});
   assign diff     = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= steps;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == lhp_pkg::DIV_STEP_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= lhp_pkg::DIV_DEN_W'(numer >> steps);
         sh_ff   <= numer << (lhp_pkg::DIV_STEP_W'(lhp_pkg::DIV_NUM_W) - steps);
         den_ff  <= denom;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= take_bit ? diff[lhp_pkg::DIV_DEN_W-1:0]
                             : trial[lhp_pkg::DIV_DEN_W-1:0];
         sh_ff   <= {sh_ff[lhp_pkg::DIV_NUM_W-2:0], 1'b0};
         quot_ff <= {quot_ff[lhp_pkg::DIV_NUM_W-2:0], take_bit};
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

### rtl/core/lhp_dp.sv
`default_nettype none

module lhp_dp #(
   parameter int unsigned MAX_BINS    = 1024,
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic                            csr_index,
   input  wire logic [31:0]                     csr_write_data,
   input  wire logic signed [31:0]              req_sample,
   input  wire lhp_pkg::lhp_cmd_type            cmd,
   output lhp_pkg::lhp_status_type              status,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [lhp_pkg::Q4_W-1:0]             rsp_median_q4,
   output logic [lhp_pkg::Q4_W-1:0]             rsp_p95_q4,
   output logic [lhp_pkg::Q4_W-1:0]             rsp_p99_q4,
   output logic [lhp_pkg::Q4_W-1:0]             rsp_peak_q4,
   output logic [lhp_pkg::JIT_W-1:0]            rsp_jitter_q8_8
);

   localparam int unsigned IW = $clog2(MAX_BINS);
   localparam int unsigned TW = COUNT_WIDTH + lhp_pkg::NBINS_W;
   localparam int unsigned MW = TW + 7;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
   localparam logic [lhp_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

   // configuration
   logic [lhp_pkg::SCALE_W-1:0] full_scale_ff;
   logic [lhp_pkg::NBINS_W-1:0] active_bins_ff;
   logic [lhp_pkg::SCALE_W-1:0] scale;
   logic [lhp_pkg::NBINS_W-1:0] nbins;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff  <= lhp_pkg::SCALE_RESET;
         active_bins_ff <= lhp_pkg::NBINS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lhp_pkg::CSR_FULL_SCALE:  full_scale_ff  <= csr_write_data;
            lhp_pkg::CSR_ACTIVE_BINS: active_bins_ff <= csr_write_data[lhp_pkg::NBINS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      scale = (full_scale_ff == '0) ? lhp_pkg::SCALE_W'(1) : full_scale_ff;
      if (active_bins_ff == '0)
         nbins = lhp_pkg::NBINS_W'(1);
      else if (32'(active_bins_ff) > 32'(MAX_BINS))
         nbins = lhp_pkg::NBINS_W'(MAX_BINS);
      else
         nbins = active_bins_ff;
   end

   // bin store
   logic [COUNT_WIDTH-1:0] mem [MAX_BINS];
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic                   mem_we;
   logic [IW-1:0]          mem_wa;
   logic [COUNT_WIDTH-1:0] mem_wd;
   logic                   mem_re;
   logic [IW-1:0]          mem_ra;

   logic [IW-1:0]          cnt_ff;
   logic [IW-1:0]          idx_ff;

   assign mem_we = cmd.clr_wr | cmd.wr_idx;
   assign mem_wa = cmd.clr_wr ? cnt_ff : idx_ff;
   assign mem_wd = cmd.clr_wr ? '0 :
                   (rd_data_ff == CNT_MAX) ? rd_data_ff : rd_data_ff + 1'b1;
   assign mem_re = cmd.walk_rd | cmd.rd_idx;
   assign mem_ra = cmd.walk_rd ? cnt_ff : idx_ff;

   always_ff @(posedge clock) begin
      if (mem_we)
         mem[mem_wa] <= mem_wd;
      if (mem_re)
         rd_data_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset)
         cnt_ff <= '0;
      else if (cmd.cnt_rst)
         cnt_ff <= '0;
      else if (cmd.cnt_inc)
         cnt_ff <= cnt_ff + 1'b1;
   end

   // sample path
   logic [lhp_pkg::SAMPLE_W-1:0]              sample_ff;
   logic [lhp_pkg::SAMPLE_W+lhp_pkg::NBINS_W-1:0] prod_ff;
   logic                                      over_ff;
   logic [lhp_pkg::TOTAL_W-1:0]               total_ff;
   logic [lhp_pkg::SAMPLE_W-1:0]              largest_ff;

   always_ff @(posedge clock) begin
      if (cmd.take)
         sample_ff <= req_sample[31] ? '0 : unsigned'(req_sample);
      if (cmd.mul) begin
         prod_ff <= (lhp_pkg::SAMPLE_W + lhp_pkg::NBINS_W)'(sample_ff) *
                    (lhp_pkg::SAMPLE_W + lhp_pkg::NBINS_W)'(nbins);
         over_ff <= (sample_ff >= scale);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= '0;
         largest_ff <= '0;
      end else if (cmd.rd_idx) begin
         if (total_ff != TOTAL_MAX)
            total_ff <= total_ff + 1'b1;
         if (sample_ff > largest_ff)
            largest_ff <= sample_ff;
      end
   end

   // walk pipeline: read, accumulate, compare
   logic          dv_ff;
   logic          chk_ff;
   logic [IW-1:0] addr_d_ff;
   logic [IW-1:0] idx2_ff;
   logic [TW-1:0] acc_ff;
   logic [MW-1:0] tgt50_ff, tgt95_ff, tgt99_ff;
   logic [MW-1:0] acc100;
   logic          f50_ff, f95_ff, f99_ff;
   logic [IW-1:0] b50_ff, b95_ff, b99_ff;

   assign acc100 = MW'(acc_ff) * MW'(lhp_pkg::PCT_ALL);

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff  <= 1'b0;
         chk_ff <= 1'b0;
      end else begin
         dv_ff  <= cmd.walk_rd;
         chk_ff <= dv_ff & cmd.walk;
      end
   end

   always_ff @(posedge clock) begin
      addr_d_ff <= cnt_ff;
      idx2_ff   <= addr_d_ff;
      if (cmd.acc_clear || cmd.tgt_load)
         acc_ff <= '0;
      else if (dv_ff)
         acc_ff <= acc_ff + TW'(rd_data_ff);
      if (cmd.tgt_load) begin
         tgt50_ff <= MW'(acc_ff) * MW'(lhp_pkg::PCT_50);
         tgt95_ff <= MW'(acc_ff) * MW'(lhp_pkg::PCT_95);
         tgt99_ff <= MW'(acc_ff) * MW'(lhp_pkg::PCT_99);
         f50_ff   <= 1'b0;
         f95_ff   <= 1'b0;
         f99_ff   <= 1'b0;
      end else if (chk_ff) begin
         if (!f50_ff && acc100 >= tgt50_ff) begin
            f50_ff <= 1'b1;
            b50_ff <= idx2_ff;
         end
         if (!f95_ff && acc100 >= tgt95_ff) begin
            f95_ff <= 1'b1;
            b95_ff <= idx2_ff;
         end
         if (!f99_ff && acc100 >= tgt99_ff) begin
            f99_ff <= 1'b1;
            b99_ff <= idx2_ff;
         end
      end
   end

   // shared divider: bin index, bin centres, ratio
   logic                            div_start;
   logic [lhp_pkg::DIV_NUM_W-1:0]   div_numer;
   logic [lhp_pkg::DIV_DEN_W-1:0]   div_denom;
   logic [lhp_pkg::DIV_STEP_W-1:0]  div_steps;
   logic                            div_done;
   logic [lhp_pkg::DIV_NUM_W-1:0]   div_quot;

   lhp_pkg::lhp_sel_type            sel_ff;
   logic [lhp_pkg::DIV_NUM_W-1:0]   cnum_ff;
   logic [lhp_pkg::DIV_DEN_W-1:0]   cden_ff;
   logic [IW-1:0]                   bsel;
   logic [lhp_pkg::ODD_W-1:0]       odd_sel;
   logic [lhp_pkg::ODD_W-1:0]       odd50;
   logic [lhp_pkg::Q4_W-1:0]        p50_ff, p95_ff, p99_ff;
   logic [lhp_pkg::JIT_W-1:0]       jit_ff;

   always_comb begin
      case (sel_ff)
         lhp_pkg::SEL_P50: bsel = b50_ff;
         lhp_pkg::SEL_P95: bsel = b95_ff;
         default:          bsel = b99_ff;
      endcase
   end

   assign odd_sel = lhp_pkg::ODD_W'({bsel, 1'b1});
   assign odd50   = lhp_pkg::ODD_W'({b50_ff, 1'b1});

   always_ff @(posedge clock) begin
      if (reset)
         sel_ff <= lhp_pkg::SEL_P50;
      else if (cmd.sel_rst)
         sel_ff <= lhp_pkg::SEL_P50;
      else if (cmd.cstore)
         sel_ff <= lhp_pkg::lhp_sel_type'(sel_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (cmd.cmul) begin
         if (sel_ff == lhp_pkg::SEL_JIT) begin
            cnum_ff <= lhp_pkg::DIV_NUM_W'({odd_sel, 8'b0});
            cden_ff <= lhp_pkg::DIV_DEN_W'(odd50);
         end else begin
            cnum_ff <= {(lhp_pkg::DIV_NUM_W-3)'(odd_sel) *
                        (lhp_pkg::DIV_NUM_W-3)'(scale), 3'b000};
            cden_ff <= lhp_pkg::DIV_DEN_W'(nbins);
         end
      end
      if (cmd.cstore) begin
         case (sel_ff)
            lhp_pkg::SEL_P50: p50_ff <= div_quot[lhp_pkg::Q4_W-1:0];
            lhp_pkg::SEL_P95: p95_ff <= div_quot[lhp_pkg::Q4_W-1:0];
            lhp_pkg::SEL_P99: p99_ff <= div_quot[lhp_pkg::Q4_W-1:0];
            default:
               jit_ff <= (div_quot > lhp_pkg::DIV_NUM_W'(16'hFFFF)) ? '1
                         : div_quot[lhp_pkg::JIT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.idx_start && over_ff)
         idx_ff <= IW'(nbins - 1'b1);
      else if (cmd.idx_from_div)
         idx_ff <= div_quot[IW-1:0];
   end

   assign div_start = (cmd.idx_start & ~over_ff) | cmd.cdiv_start;
   assign div_numer = cmd.cdiv_start ? cnum_ff : lhp_pkg::DIV_NUM_W'(prod_ff);
   assign div_denom = cmd.cdiv_start ? cden_ff : scale;
   assign div_steps = cmd.cdiv_start ? lhp_pkg::STEPS_FULL : lhp_pkg::STEPS_INDEX;

   lhp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .steps (div_steps),
      .done  (div_done),
      .quot  (div_quot)
   );

   // result register
   logic                        rsp_valid_ff;
   logic [lhp_pkg::Q4_W-1:0]    o_p50_ff, o_p95_ff, o_p99_ff, o_peak_ff;
   logic [lhp_pkg::JIT_W-1:0]   o_jit_ff;
   logic [lhp_pkg::Q4_W-1:0]    peak_in;
   logic                        out_free;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign peak_in  = ({largest_ff, 4'b0000} > p99_ff) ? {largest_ff, 4'b0000} : p99_ff;

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.out_load || cmd.out_zero)
         rsp_valid_ff <= 1'b1;
      else if (!rsp_stall)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         o_p50_ff  <= p50_ff;
         o_p95_ff  <= p95_ff;
         o_p99_ff  <= p99_ff;
         o_peak_ff <= peak_in;
         o_jit_ff  <= jit_ff;
      end else if (cmd.out_zero) begin
         o_p50_ff  <= '0;
         o_p95_ff  <= '0;
         o_p99_ff  <= '0;
         o_peak_ff <= '0;
         o_jit_ff  <= '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_median_q4   = o_p50_ff;
   assign rsp_p95_q4      = o_p95_ff;
   assign rsp_p99_q4      = o_p99_ff;
   assign rsp_peak_q4     = o_peak_ff;
   assign rsp_jitter_q8_8 = o_jit_ff;

   always_comb begin
      status.over       = over_ff;
      status.clr_last   = (32'(cnt_ff) == 32'(MAX_BINS - 1));
      status.walk_last  = (32'(cnt_ff) == 32'(nbins) - 32'd1);
      status.div_done   = div_done;
      status.pipe_busy  = dv_ff | chk_ff;
      status.total_zero = (total_ff == '0);
      status.sel_last   = (sel_ff == lhp_pkg::SEL_JIT);
      status.out_free   = out_free;
   end

endmodule

`default_nettype wire

### rtl/core/lhp_ctrl.sv
`default_nettype none

module lhp_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_mode,
   output logic                           req_stall,
   input  wire lhp_pkg::lhp_status_type   status,
   output lhp_pkg::lhp_cmd_type           cmd
);

   lhp_pkg::lhp_state_type state_ff, state_in;
   logic                   zero_ff, zero_in;
   logic                   accept;

   assign req_stall = (state_ff != lhp_pkg::ST_IDLE);
   assign accept    = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lhp_pkg::ST_CLEAR;
         zero_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         zero_ff  <= zero_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      zero_in  = zero_ff;
      unique case (state_ff)
         lhp_pkg::ST_CLEAR:
            if (status.clr_last) state_in = lhp_pkg::ST_IDLE;
         lhp_pkg::ST_IDLE:
            if (accept) begin
               if (!req_mode) begin
                  state_in = lhp_pkg::ST_MUL;
               end else if (status.total_zero) begin
                  state_in = lhp_pkg::ST_OUT;
                  zero_in  = 1'b1;
               end else begin
                  state_in = lhp_pkg::ST_SUM;
                  zero_in  = 1'b0;
               end
            end
         lhp_pkg::ST_MUL:      state_in = lhp_pkg::ST_IDX;
         lhp_pkg::ST_IDX:
            state_in = status.over ? lhp_pkg::ST_READ : lhp_pkg::ST_IDX_WAIT;
         lhp_pkg::ST_IDX_WAIT:
            if (status.div_done) state_in = lhp_pkg::ST_READ;
         lhp_pkg::ST_READ:     state_in = lhp_pkg::ST_WRITE;
         lhp_pkg::ST_WRITE:    state_in = lhp_pkg::ST_IDLE;
         lhp_pkg::ST_SUM:
            if (status.walk_last) state_in = lhp_pkg::ST_SUM_DRAIN;
         lhp_pkg::ST_SUM_DRAIN:
            if (!status.pipe_busy) state_in = lhp_pkg::ST_TARGET;
         lhp_pkg::ST_TARGET:   state_in = lhp_pkg::ST_WALK;
         lhp_pkg::ST_WALK:
            if (status.walk_last) state_in = lhp_pkg::ST_WALK_DRAIN;
         lhp_pkg::ST_WALK_DRAIN:
            if (!status.pipe_busy) state_in = lhp_pkg::ST_CMUL;
         lhp_pkg::ST_CMUL:     state_in = lhp_pkg::ST_CDIV;
         lhp_pkg::ST_CDIV:     state_in = lhp_pkg::ST_CWAIT;
         lhp_pkg::ST_CWAIT:
            if (status.div_done)
               state_in = status.sel_last ? lhp_pkg::ST_OUT : lhp_pkg::ST_CMUL;
         lhp_pkg::ST_OUT:
            if (status.out_free) state_in = lhp_pkg::ST_IDLE;
         default:              state_in = lhp_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         lhp_pkg::ST_CLEAR: begin
            cmd.clr_wr  = 1'b1;
            cmd.cnt_inc = 1'b1;
         end
         lhp_pkg::ST_IDLE: begin
            cmd.cnt_rst   = 1'b1;
            cmd.acc_clear = 1'b1;
            cmd.take      = accept;
         end
         lhp_pkg::ST_MUL:      cmd.mul = 1'b1;
         lhp_pkg::ST_IDX:      cmd.idx_start = 1'b1;
         lhp_pkg::ST_IDX_WAIT: cmd.idx_from_div = status.div_done;
         lhp_pkg::ST_READ:     cmd.rd_idx = 1'b1;
         lhp_pkg::ST_WRITE:    cmd.wr_idx = 1'b1;
         lhp_pkg::ST_SUM: begin
            cmd.walk_rd = 1'b1;
            cmd.cnt_inc = 1'b1;
         end
         lhp_pkg::ST_SUM_DRAIN: ;
         lhp_pkg::ST_TARGET: begin
            cmd.tgt_load = 1'b1;
            cmd.cnt_rst  = 1'b1;
            cmd.sel_rst  = 1'b1;
         end
         lhp_pkg::ST_WALK: begin
            cmd.walk_rd = 1'b1;
            cmd.cnt_inc = 1'b1;
            cmd.walk    = 1'b1;
         end
         lhp_pkg::ST_WALK_DRAIN: cmd.walk = 1'b1;
         lhp_pkg::ST_CMUL:     cmd.cmul = 1'b1;
         lhp_pkg::ST_CDIV:     cmd.cdiv_start = 1'b1;
         lhp_pkg::ST_CWAIT:    cmd.cstore = status.div_done;
         lhp_pkg::ST_OUT: begin
            cmd.out_load = status.out_free & ~zero_ff;
            cmd.out_zero = status.out_free & zero_ff;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/lhp_checker.sv
`default_nettype none

module lhp_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_stall,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire logic [35:0]  rsp_median_q4,
   input wire logic [35:0]  rsp_p95_q4,
   input wire logic [35:0]  rsp_p99_q4,
   input wire logic [35:0]  rsp_peak_q4,
   input wire logic [15:0]  rsp_jitter_q8_8
);

   // clearing pass holds off requests, result register empties
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (req_stall && !rsp_valid))
      else $error("no stall or stale result after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_median_q4) &&
                                    $stable(rsp_p99_q4) && $stable(rsp_jitter_q8_8)))
      else $error("stalled result changed");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_median_q4 <= rsp_p95_q4 && rsp_p95_q4 <= rsp_p99_q4))
      else $error("percentiles out of order");

   a_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_peak_q4 >= rsp_p99_q4))
      else $error("peak below p99");

   // zero ratio only for an empty histogram
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_jitter_q8_8 == 16'd0) |-> (rsp_p99_q4 == 36'd0 &&
                                                   rsp_peak_q4 == 36'd0))
      else $error("zero ratio with nonzero result");

endmodule

bind latency_histogram_percentiles lhp_checker u_lhp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_median_q4   (rsp_median_q4),
   .rsp_p95_q4      (rsp_p95_q4),
   .rsp_p99_q4      (rsp_p99_q4),
   .rsp_peak_q4     (rsp_peak_q4),
   .rsp_jitter_q8_8 (rsp_jitter_q8_8)
);

`default_nettype wire

### verif/latency_histogram_percentiles_checker.sv
`timescale 1ns / 100ps

module latency_histogram_percentiles_checker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_stall,
   input  wire logic                       req_mode,
   input  wire logic signed [31:0]         req_sample,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   input  wire logic [lhp_pkg::Q4_W-1:0]   rsp_median_q4,
   input  wire logic [lhp_pkg::Q4_W-1:0]   rsp_p95_q4,
   input  wire logic [lhp_pkg::Q4_W-1:0]   rsp_p99_q4,
   input  wire logic [lhp_pkg::Q4_W-1:0]   rsp_peak_q4,
   input  wire logic [lhp_pkg::JIT_W-1:0]  rsp_jitter_q8_8,
   input  wire logic                       csr_write_enable,
   input  wire logic                       csr_index,
   input  wire logic [31:0]                csr_write_data,
   output int                              error_count,
   output int                              reports_pending,
   output int                              reports_checked
);

   localparam int NUM_BINS = 1024;
   localparam longint unsigned COUNT_MAX = 64'hFFFF_FFFF;
   localparam longint unsigned TOTAL_MAX = 64'hFFFF_FFFF_FFFF;
   localparam longint unsigned Q4_MASK   = 64'hF_FFFF_FFFF;

   typedef struct packed {
      logic [lhp_pkg::Q4_W-1:0]  median;
      logic [lhp_pkg::Q4_W-1:0]  p95;
      logic [lhp_pkg::Q4_W-1:0]  p99;
      logic [lhp_pkg::Q4_W-1:0]  peak;
      logic [lhp_pkg::JIT_W-1:0] jitter;
   } percentile_report_type;

   longint unsigned             bin_count [NUM_BINS];
   longint unsigned             total_samples;
   longint unsigned             max_latency;
   logic [lhp_pkg::SCALE_W-1:0] scale_reg;
   logic [lhp_pkg::NBINS_W-1:0] bins_reg;
   percentile_report_type       expected_reports [$];

   assign reports_pending = expected_reports.size();

   function automatic longint unsigned scale_eff();
      return (scale_reg == '0) ? 64'd1 : 64'(scale_reg);
   endfunction

   function automatic longint unsigned bins_eff();
      if (bins_reg == '0) return 1;
      if (bins_reg > NUM_BINS) return NUM_BINS;
      return 64'(bins_reg);
   endfunction

   // ceil(t*pct/100)
   function automatic longint unsigned rank_for(longint unsigned t, longint unsigned pct);
      return (t * pct + 99) / 100;
   endfunction

   function automatic longint unsigned first_bin_reaching(longint unsigned k,
                                                        longint unsigned nb);
      longint unsigned acc;
      acc = 0;
      for (longint unsigned i = 0; i < nb; i++) begin
         acc += bin_count[i];
         if (acc >= k) return i;
      end
      return nb;
   endfunction

   function automatic longint unsigned centre_of(longint unsigned i, longint unsigned nb);
      if (i >= nb) return (scale_eff() << 4) & Q4_MASK;
      return (((2 * i + 1) * scale_eff() * 8) / nb) & Q4_MASK;
   endfunction

   function automatic percentile_report_type predict_report();
      percentile_report_type r;
      longint unsigned nb, t, b50, b95, b99, p99, peak, jit;
      r = '0;
      if (total_samples == 0) return r;
      nb = bins_eff();
      t = 0;
      for (longint unsigned i = 0; i < nb; i++) t += bin_count[i];
      b50 = first_bin_reaching(rank_for(t, lhp_pkg::PCT_50), nb);
      b95 = first_bin_reaching(rank_for(t, lhp_pkg::PCT_95), nb);
      b99 = first_bin_reaching(rank_for(t, lhp_pkg::PCT_99), nb);
      p99 = centre_of(b99, nb);
      peak = (max_latency << 4) & Q4_MASK;
      if (p99 > peak) peak = p99;
      if (b50 >= nb || b99 >= nb) jit = 256;
      else begin
         jit = ((2 * b99 + 1) * 256) / (2 * b50 + 1);
         if (jit > 64'hFFFF) jit = 64'hFFFF;
      end
      r.median = centre_of(b50, nb);
      r.p95    = centre_of(b95, nb);
      r.p99    = p99;
      r.peak   = peak;
      r.jitter = jit[lhp_pkg::JIT_W-1:0];
      return r;
   endfunction

   function automatic void add_latency(logic signed [31:0] raw);
      longint unsigned s, idx, nb;
      nb = bins_eff();
      s = raw[31] ? 64'd0 : 64'(raw);
      idx = (s * nb) / scale_eff();
      if (idx > nb - 1) idx = nb - 1;
      if (bin_count[idx] < COUNT_MAX) bin_count[idx]++;
      if (total_samples < TOTAL_MAX) total_samples++;
      if (s > max_latency) max_latency = s;
   endfunction

   always @(posedge clock) begin
      percentile_report_type want;
      if (reset) begin
         foreach (bin_count[i]) bin_count[i] = 0;
         total_samples = 0;
         max_latency   = 0;
         scale_reg     = lhp_pkg::SCALE_RESET;
         bins_reg      = lhp_pkg::NBINS_RESET;
         expected_reports.delete();
         error_count     <= 0;
         reports_checked <= 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == lhp_pkg::CSR_FULL_SCALE) scale_reg = csr_write_data;
            else bins_reg = csr_write_data[lhp_pkg::NBINS_W-1:0];
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $error("unexpected report transaction");
               error_count <= error_count + 1;
            end else begin
               want = expected_reports.pop_front();
               reports_checked <= reports_checked + 1;
               if (want !== {rsp_median_q4, rsp_p95_q4, rsp_p99_q4, rsp_peak_q4,
                             rsp_jitter_q8_8}) begin
                  if (want.median !== rsp_median_q4)
                     $error("median_q4 exp %0d got %0d", want.median, rsp_median_q4);
                  if (want.p95 !== rsp_p95_q4)
                     $error("p95_q4 exp %0d got %0d", want.p95, rsp_p95_q4);
                  if (want.p99 !== rsp_p99_q4)
                     $error("p99_q4 exp %0d got %0d", want.p99, rsp_p99_q4);
                  if (want.peak !== rsp_peak_q4)
                     $error("peak_q4 exp %0d got %0d", want.peak, rsp_peak_q4);
                  if (want.jitter !== rsp_jitter_q8_8)
                     $error("jitter_q8_8 exp %0d got %0d", want.jitter, rsp_jitter_q8_8);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_mode)
               expected_reports.insert(expected_reports.size(), predict_report());
            else add_latency(req_sample);
         end
      end
   end

endmodule

### verif/latency_histogram_percentiles_tb.sv
`timescale 1ns / 100ps

module latency_histogram_percentiles_tb;

   localparam int WATCHDOG_LIMIT = 20000;   // idle cycles; slowest report + long hold-off
   localparam int HOLD_CYCLES    = 3000;
   localparam int SETTLE_CYCLES  = 40;      // add transaction has no result

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_mode = 1'b0;
   logic signed [31:0]           req_sample = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [lhp_pkg::Q4_W-1:0]     rsp_median_q4, rsp_p95_q4, rsp_p99_q4, rsp_peak_q4;
   logic [lhp_pkg::JIT_W-1:0]    rsp_jitter_q8_8;
   logic                         csr_write_enable = 1'b0;
   logic                         csr_index = lhp_pkg::CSR_FULL_SCALE;
   logic [31:0]                  csr_write_data = '0;

   int error_count, reports_pending, reports_checked;
   int burst_left = 0;
   int samples_sent = 0, reports_sent = 0, phases_run = 0;
   int hold_requests = 0;
   logic [31:0] scale_now = lhp_pkg::SCALE_RESET;

   always #6 clock = ~clock;

   latency_histogram_percentiles DUT (.*);

   latency_histogram_percentiles_checker u_checker (.*);

   // receiver: stall pattern picked at random among none / light / heavy;
   // a hold-off request forces a long stall so the block backs up
   always @(negedge clock) begin
      static int cyc = 0;
      static int level = 0;
      static int hold_left = 0;
      static int hold_served = 0;
      if (hold_left > 0) hold_left--;
      else if (hold_served < hold_requests) begin
         hold_served++;
         hold_left = HOLD_CYCLES;
      end
      if (cyc % 64 == 0) level = $urandom_range(0, 2);
      cyc++;
      if (hold_left > 0) rsp_stall = 1'b1;
      else case (level)
         0: rsp_stall = 1'b0;
         1: rsp_stall = ($urandom_range(0, 3) == 0);
         default: rsp_stall = ($urandom_range(0, 9) < 6);
      endcase
   end

   // watchdog: cycles without any accepted transaction
   always @(posedge clock) begin
      static int quiet = 0;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || csr_write_enable)
         quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
         $display("latency_histogram_percentiles_tb: errors");
         $finish;
      end
   end

   // called at a falling edge, returns at a falling edge after acceptance
   task automatic send_txn(logic mode, logic [31:0] value, bit no_gap = 0);
      if (!no_gap && burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end
      if (burst_left > 0) burst_left--;
      req_valid  = 1'b1;
      req_mode   = mode;
      req_sample = value;
      do @(posedge clock); while (req_stall);
      if (mode) reports_sent++;
      else samples_sent++;
      @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] data);
      req_valid        = 1'b0;
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (idx == lhp_pkg::CSR_FULL_SCALE) scale_now = data;
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (reports_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // mostly in range, some negative, some above full scale, some fully random
   function automatic logic [31:0] pick_latency();
      logic [31:0] top;
      top = (scale_now == 0) ? 32'd1 : scale_now;
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'h8000_0000 | $urandom();
         2: return top + $urandom_range(0, 1000);
         default: return $urandom_range(0, top - 1);
      endcase
   endfunction

   task automatic random_phase(int count, int report_odds);
      repeat (count) begin
         if ($urandom_range(1, report_odds) == 1) send_txn(1'b1, $urandom());
         else send_txn(1'b0, pick_latency());
      end
      drain();
      phases_run++;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty report, then field extremes at reset config
      send_txn(1'b1, 32'hFFFF_FFFF);
      send_txn(1'b0, 32'd0);
      send_txn(1'b0, 32'hFFFF_FFFF);            // -1 clamps to zero
      send_txn(1'b0, 32'h8000_0000);            // most negative
      send_txn(1'b0, 32'h7FFF_FFFF);            // far past full scale
      send_txn(1'b0, lhp_pkg::SCALE_RESET - 1);
      send_txn(1'b0, lhp_pkg::SCALE_RESET);
      send_txn(1'b1, 32'h0);
      drain();

      // shrinking the active range keeps old bins out of the walk
      write_csr(lhp_pkg::CSR_ACTIVE_BINS, 32'd4);
      send_txn(1'b1, 32'h5A5A_5A5A);
      send_txn(1'b0, lhp_pkg::SCALE_RESET / 2);
      send_txn(1'b1, 32'h0);
      drain();

      // zero full scale and zero bins act as one
      write_csr(lhp_pkg::CSR_FULL_SCALE, 32'd0);
      write_csr(lhp_pkg::CSR_ACTIVE_BINS, 32'd0);
      send_txn(1'b0, 32'd0);
      send_txn(1'b0, 32'd5);
      send_txn(1'b1, 32'h0);
      drain();

      // widest scale, bin count above the maximum
      write_csr(lhp_pkg::CSR_FULL_SCALE, 32'hFFFF_FFFF);
      write_csr(lhp_pkg::CSR_ACTIVE_BINS, 32'h7FF);
      send_txn(1'b0, 32'h7FFF_FFFF);
      send_txn(1'b0, 32'd1);
      send_txn(1'b1, 32'h0);
      drain();

      // random phases over a spread of settings
      write_csr(lhp_pkg::CSR_FULL_SCALE, 32'd1);
      write_csr(lhp_pkg::CSR_ACTIVE_BINS, 32'd1);
      random_phase(150, 10);

      write_csr(lhp_pkg::CSR_FULL_SCALE, 32'd1000);
      write_csr(lhp_pkg::CSR_ACTIVE_BINS, 32'd8);
      random_phase(300, 12);

      // long hold-off: results back up, report stalls on the full output register
      hold_requests++;
      for (int i = 0; i < 40; i++)
         send_txn(i % 10 == 9, pick_latency(), 1'b1);
      drain();

      write_csr(lhp_pkg::CSR_FULL_SCALE, 32'd50);
      write_csr(lhp_pkg::CSR_ACTIVE_BINS, 32'd2047);
      random_phase(250, 20);

      write_csr(lhp_pkg::CSR_FULL_SCALE, $urandom_range(2, 100000));
      write_csr(lhp_pkg::CSR_ACTIVE_BINS, $urandom_range(2, 64));
      random_phase(350, 10);

      write_csr(lhp_pkg::CSR_FULL_SCALE, 32'hFFFF_FFFF);
      write_csr(lhp_pkg::CSR_ACTIVE_BINS, 32'd1024);
      random_phase(200, 25);

      write_csr(lhp_pkg::CSR_FULL_SCALE, $urandom());
      write_csr(lhp_pkg::CSR_ACTIVE_BINS, $urandom_range(1, 32));
      random_phase(300, 10);

      $display("covered %0d samples and %0d reports over %0d random setups;",
               samples_sent, reports_sent, phases_run);
      $display("%0d reports compared, %0d mismatching", reports_checked, error_count);
      if (error_count == 0) $display("latency_histogram_percentiles_tb: clean");
      else $display("latency_histogram_percentiles_tb: errors");
      $finish;
   end

endmodule

### filelist.f
rtl/core/lhp_pkg.sv
rtl/core/lhp_div.sv
rtl/core/lhp_dp.sv
rtl/core/lhp_ctrl.sv
rtl/core/latency_histogram_percentiles.sv
rtl/core/lhp_checker.sv
verif/latency_histogram_percentiles_checker.sv
verif/latency_histogram_percentiles_tb.sv
